// ----- rtl/chacha_pkg.sv -----
// chacha_pkg: shared types, constants and helper functions for the chacha20 stream core
// used by chacha_qr and chacha20_stream_xor_core; no dependencies
package chacha_pkg;

    localparam int WORD_W      = 32;
    localparam int WORDS       = 16;
    localparam int WADDR_W     = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_W       = 7;
    localparam int LAST_ROUND  = 9;

    localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER  = 3'd6;

    // quarter-round step codes
    localparam logic [1:0] QR_STEP_A16 = 2'd0;
    localparam logic [1:0] QR_STEP_C12 = 2'd1;
    localparam logic [1:0] QR_STEP_A8  = 2'd2;
    localparam logic [1:0] QR_STEP_C7  = 2'd3;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_XOR,
        ST_INIT,
        ST_QLOAD,
        ST_QCALC,
        ST_QSTORE,
        ST_FINAL
    } state_t;

    // control from the sequencer to the quarter-round unit
    typedef struct packed {
        logic       load;
        logic       step;
        logic [1:0] sel;
    } qr_ctrl_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v, input int s);
        rotl32 = (v << s) | (v >> (WORD_W - s));
    endfunction

    // state word index for quarter-round qsel (0..3 columns, 4..7 diagonals) and role a/b/c/d
    function automatic logic [WADDR_W-1:0] qr_index(input logic [2:0] qsel,
                                                   input logic [1:0] role);
        logic [1:0] lane;
        lane = qsel[1:0] + (qsel[2] ? role : 2'd0);
        qr_index = {role, lane};
    endfunction

endpackage

// ----- rtl/chacha_ram.sv -----
// chacha_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module chacha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/chacha_qr.sv -----
// chacha_qr: quarter-round unit, four word registers and one add/xor/rotate step per cycle while step is set
// depends on chacha_pkg
module chacha_qr (
    input  logic                           clk,
    input  chacha_pkg::qr_ctrl_t           ctrl,
    input  logic [chacha_pkg::WORD_W-1:0]  load_data,
    input  logic [1:0]                     out_sel,
    output logic [chacha_pkg::WORD_W-1:0]  out_word
);

    logic [chacha_pkg::WORD_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [chacha_pkg::WORD_W-1:0] a_next, b_next, c_next, d_next;
    logic [chacha_pkg::WORD_W-1:0] sum;

    // one dependent add, xor and rotate per step
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        sum    = '0;
        if (ctrl.load)
        begin
            unique case (ctrl.sel)
                2'd0: a_next = load_data;
                2'd1: b_next = load_data;
                2'd2: c_next = load_data;
                default: d_next = load_data;
            endcase
        end
        else if (ctrl.step)
        begin
            unique case (ctrl.sel)
                chacha_pkg::QR_STEP_A16:
                begin
                    sum    = a_reg + b_reg;
                    a_next = sum;
                    d_next = chacha_pkg::rotl32(d_reg ^ sum, 16);
                end
                chacha_pkg::QR_STEP_C12:
                begin
                    sum    = c_reg + d_reg;
                    c_next = sum;
                    b_next = chacha_pkg::rotl32(b_reg ^ sum, 12);
                end
                chacha_pkg::QR_STEP_A8:
                begin
                    sum    = a_reg + b_reg;
                    a_next = sum;
                    d_next = chacha_pkg::rotl32(d_reg ^ sum, 8);
                end
                default:
                begin
                    sum    = c_reg + d_reg;
                    c_next = sum;
                    b_next = chacha_pkg::rotl32(b_reg ^ sum, 7);
                end
            endcase
        end
    end

    // working words
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    // write-back word select
    always_comb
    begin
        unique case (out_sel)
            2'd0: out_word = a_reg;
            2'd1: out_word = b_reg;
            2'd2: out_word = c_reg;
            default: out_word = d_reg;
        endcase
    end

endmodule

// ----- rtl/chacha20_stream_xor_core.sv -----
// chacha20_stream_xor_core: one byte per word, xor with chacha20 keystream, last passes through
// an accepted byte goes to the xor state, which xors it with its keystream byte and registers
// the result once the output register is free; no new byte is taken before then. a new 64-byte
// block takes 16 init writes, 80 quarter-rounds (each 4 ram reads, 4 steps, 4 ram write-backs)
// and the final add; one state ram access per port and cycle sets the block time; reset
// (async, rst_n low) clears config to zero and forces a fresh block before the first byte;
// depends on chacha_pkg, chacha_ram, chacha_qr
module chacha20_stream_xor_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] data_in
    input  logic                               s_axis_tlast,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // [7:0] data_out
    output logic                               m_axis_tlast
);

    localparam int WW = chacha_pkg::WORD_W;
    localparam int AW = chacha_pkg::WADDR_W;

    chacha_pkg::state_t state_reg, state_next;

    logic [chacha_pkg::CFG_DATA_W-1:0] key_reg [4];
    logic [chacha_pkg::CFG_DATA_W-1:0] nonce_lo_reg;
    logic [WW-1:0]                     nonce_hi_reg;
    logic [WW-1:0]                     init_ctr_reg;

    logic [WW-1:0]                     ctr_reg, ctr_next;
    logic [WW-1:0]                     nonce0_reg, nonce0_next;
    logic [chacha_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [4:0]                        sub_reg, sub_next;
    logic [2:0]                        qsel_reg, qsel_next;
    logic [3:0]                        round_reg, round_next;
    logic [7:0]                        data_reg, data_next;
    logic                              last_reg, last_next;
    logic [1:0]                        bsel_reg, bsel_next;
    logic                              out_valid_reg, out_valid_next;
    logic [7:0]                        out_data_reg, out_data_next;
    logic                              out_last_reg, out_last_next;

    logic                              ram_we, ram_re;
    logic [AW-1:0]                     ram_waddr, ram_raddr;
    logic [WW-1:0]                     ram_wdata, ram_rdata;
    chacha_pkg::qr_ctrl_t              qc;
    logic [WW-1:0]                     qr_word;
    logic [AW-1:0]                     iw_idx;
    logic [WW-1:0]                     iw;
    logic [7:0]                        ks_byte;
    logic                              cfg_hit;

    // block state memory: working words, then keystream words
    chacha_ram #(
        .WIDTH (WW),
        .DEPTH (chacha_pkg::WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    chacha_qr u_qr (
        .clk       (clk),
        .ctrl      (qc),
        .load_data (ram_rdata),
        .out_sel   (sub_reg[1:0]),
        .out_word  (qr_word)
    );

    // initial block word for the current init or final-add index
    always_comb
    begin
        iw_idx = (state_reg == chacha_pkg::ST_INIT) ? sub_reg[AW-1:0] : sub_reg[AW-1:0] - 4'd1;
        unique case (iw_idx)
            4'd0:  iw = chacha_pkg::SIGMA0;
            4'd1:  iw = chacha_pkg::SIGMA1;
            4'd2:  iw = chacha_pkg::SIGMA2;
            4'd3:  iw = chacha_pkg::SIGMA3;
            4'd4:  iw = key_reg[0][31:0];
            4'd5:  iw = key_reg[0][63:32];
            4'd6:  iw = key_reg[1][31:0];
            4'd7:  iw = key_reg[1][63:32];
            4'd8:  iw = key_reg[2][31:0];
            4'd9:  iw = key_reg[2][63:32];
            4'd10: iw = key_reg[3][31:0];
            4'd11: iw = key_reg[3][63:32];
            4'd12: iw = ctr_reg;
            4'd13: iw = nonce0_reg;
            4'd14: iw = nonce_lo_reg[63:32];
            default: iw = nonce_hi_reg;
        endcase
    end

    // keystream byte, little-endian within the word
    always_comb
    begin
        unique case (bsel_reg)
            2'd0: ks_byte = ram_rdata[7:0];
            2'd1: ks_byte = ram_rdata[15:8];
            2'd2: ks_byte = ram_rdata[23:16];
            default: ks_byte = ram_rdata[31:24];
        endcase
    end

    assign cfg_hit = cfg_we && (cfg_index <= chacha_pkg::CFG_COUNTER);

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        nonce0_next    = nonce0_reg;
        pos_next       = pos_reg;
        sub_next       = sub_reg;
        qsel_next      = qsel_reg;
        round_next     = round_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        bsel_next      = bsel_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        qc             = '0;
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            chacha_pkg::ST_RUN:
            begin
                if (pos_reg[chacha_pkg::POS_W-1])
                begin
                    state_next = chacha_pkg::ST_INIT;
                    sub_next   = '0;
                end
                else
                begin
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = pos_reg[5:2];
                        data_next  = s_axis_tdata;
                        last_next  = s_axis_tlast;
                        bsel_next  = pos_reg[1:0];
                        pos_next   = pos_reg + 7'd1;
                        state_next = chacha_pkg::ST_XOR;
                    end
                end
            end
            chacha_pkg::ST_XOR:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = data_reg ^ ks_byte;
                    out_last_next  = last_reg;
                    state_next     = chacha_pkg::ST_RUN;
                end
            end
            chacha_pkg::ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = sub_reg[AW-1:0];
                ram_wdata = iw;
                if (sub_reg[AW-1:0] == 4'd15)
                begin
                    state_next = chacha_pkg::ST_QLOAD;
                    sub_next   = '0;
                    qsel_next  = '0;
                    round_next = '0;
                end
                else
                begin
                    sub_next = sub_reg + 5'd1;
                end
            end
            chacha_pkg::ST_QLOAD:
            begin
                // read issued at sub, captured in the next cycle
                if (sub_reg != 5'd4)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = chacha_pkg::qr_index(qsel_reg, sub_reg[1:0]);
                end
                if (sub_reg != 5'd0)
                begin
                    qc.load = 1'b1;
                    qc.sel  = sub_reg[1:0] - 2'd1;
                end
                if (sub_reg == 5'd4)
                begin
                    state_next = chacha_pkg::ST_QCALC;
                    sub_next   = '0;
                end
                else
                begin
                    sub_next = sub_reg + 5'd1;
                end
            end
            chacha_pkg::ST_QCALC:
            begin
                qc.step = 1'b1;
                qc.sel  = sub_reg[1:0];
                if (sub_reg == 5'd3)
                begin
                    state_next = chacha_pkg::ST_QSTORE;
                    sub_next   = '0;
                end
                else
                begin
                    sub_next = sub_reg + 5'd1;
                end
            end
            chacha_pkg::ST_QSTORE:
            begin
                // write-back ends before the next quarter-round reads, so no forwarding
                ram_we    = 1'b1;
                ram_waddr = chacha_pkg::qr_index(qsel_reg, sub_reg[1:0]);
                ram_wdata = qr_word;
                if (sub_reg == 5'd3)
                begin
                    sub_next  = '0;
                    qsel_next = qsel_reg + 3'd1;
                    if (qsel_reg == 3'd7 && round_reg == 4'(chacha_pkg::LAST_ROUND))
                    begin
                        state_next = chacha_pkg::ST_FINAL;
                    end
                    else
                    begin
                        state_next = chacha_pkg::ST_QLOAD;
                        if (qsel_reg == 3'd7)
                        begin
                            round_next = round_reg + 4'd1;
                        end
                    end
                end
                else
                begin
                    sub_next = sub_reg + 5'd1;
                end
            end
            chacha_pkg::ST_FINAL:
            begin
                // read word sub, add initial word and write back in the next cycle
                if (!sub_reg[4])
                begin
                    ram_re    = 1'b1;
                    ram_raddr = sub_reg[AW-1:0];
                end
                if (sub_reg != 5'd0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = iw_idx;
                    ram_wdata = ram_rdata + iw;
                end
                if (sub_reg[4])
                begin
                    ctr_next = ctr_reg + 32'd1;
                    if (ctr_reg == '1)
                    begin
                        nonce0_next = nonce0_reg + 32'd1;
                    end
                    pos_next   = '0;
                    sub_next   = '0;
                    state_next = chacha_pkg::ST_RUN;
                end
                else
                begin
                    sub_next = sub_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = chacha_pkg::ST_RUN;
            end
        endcase

        // a write to a used configuration index restarts the stream
        if (cfg_hit)
        begin
            ctr_next    = (cfg_index == chacha_pkg::CFG_COUNTER) ? cfg_data[31:0] : init_ctr_reg;
            nonce0_next = (cfg_index == chacha_pkg::CFG_NONCE_LO) ? cfg_data[31:0]
                                                                   : nonce_lo_reg[31:0];
            pos_next    = 7'd64;
            state_next  = chacha_pkg::ST_RUN;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]   <= '0;
            key_reg[1]   <= '0;
            key_reg[2]   <= '0;
            key_reg[3]   <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            init_ctr_reg <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (cfg_index)
                chacha_pkg::CFG_KEY0:     key_reg[0]   <= cfg_data;
                chacha_pkg::CFG_KEY1:     key_reg[1]   <= cfg_data;
                chacha_pkg::CFG_KEY2:     key_reg[2]   <= cfg_data;
                chacha_pkg::CFG_KEY3:     key_reg[3]   <= cfg_data;
                chacha_pkg::CFG_NONCE_LO: nonce_lo_reg <= cfg_data;
                chacha_pkg::CFG_NONCE_HI: nonce_hi_reg <= cfg_data[31:0];
                default:                  init_ctr_reg <= cfg_data[31:0];
            endcase
        end
    end

    // control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chacha_pkg::ST_RUN;
            ctr_reg       <= '0;
            nonce0_reg    <= '0;
            pos_reg       <= 7'd64;
            sub_reg       <= '0;
            qsel_reg      <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            nonce0_reg    <= nonce0_next;
            pos_reg       <= pos_next;
            sub_reg       <= sub_next;
            qsel_reg      <= qsel_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        last_reg     <= last_next;
        bsel_reg     <= bsel_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // no state ram write while bytes are served
    a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chacha_pkg::ST_RUN || state_reg == chacha_pkg::ST_XOR) |-> !ram_we)
        else $error("state ram written while serving bytes");

    // an accepted byte goes to the xor stage
    a_accept_to_xor: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !cfg_we) |=> (state_reg == chacha_pkg::ST_XOR))
        else $error("accepted byte did not reach xor stage");

    // byte position never passes one block
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !(pos_reg[chacha_pkg::POS_W-1] && (pos_reg[5:0] != 6'd0)))
        else $error("byte position out of range");

    // round counter never passes the last double round
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= 4'(chacha_pkg::LAST_ROUND))
        else $error("round counter out of range");

    // a new block starts at byte zero
    a_block_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chacha_pkg::ST_FINAL && sub_reg[4] && !cfg_we) |=> (pos_reg == 7'd0))
        else $error("byte position not cleared after block");

endmodule

// ----- dv/chacha20_stream_xor_core_test.sv -----
// chacha20_stream_xor_core_test: self-checking bench for the chacha20 stream xor core
// predicts each output byte with its own chacha20 keystream generator; depends on chacha_pkg
`timescale 1ns / 100ps

// keeps the predicted output words in arrival order and compares results
class xor_byte_board;
    logic [7:0] exp_data[$];
    logic       exp_last[$];
    int         errors;
    int         checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    // one line per mismatch, counted
    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function void note_input(logic [7:0] d, logic l);
        exp_data.push_back(d);
        exp_last.push_back(l);
    endfunction

    task check_result(logic [7:0] d, logic l);
        logic [7:0] ed;
        logic       el;
        if (exp_data.size() == 0)
        begin
            report($sformatf("output word %h with nothing expected", d));
            return;
        end
        ed = exp_data.pop_front();
        el = exp_last.pop_front();
        checked++;
        if (d !== ed)
            report($sformatf("data %h, expected %h (word %0d)", d, ed, checked));
        if (l !== el)
            report($sformatf("last %b, expected %b (word %0d)", l, el, checked));
    endtask

    function int pending();
        return exp_data.size();
    endfunction
endclass

module chacha20_stream_xor_core_test;

    localparam int  N_RANDOM    = 760;
    localparam int  BLOCK_WAIT  = 1300;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int  IDX_W       = chacha_pkg::CFG_IDX_W;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata;   // [7:0] data_in
    logic                               s_axis_tlast;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [7:0]                         m_axis_tdata;   // [7:0] data_out
    logic                               m_axis_tlast;

    chacha20_stream_xor_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    xor_byte_board board;

    // predictor copy of registers and stream state
    logic [63:0] key_reg[4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] ctr_init_reg;
    logic [31:0] blk_ctr;
    logic [31:0] nonce_w0;
    logic [31:0] ks_words[16];
    int          ks_pos;

    bit     quiet_phase;
    longint cycles;
    int     rx_total;
    int     blocks_made;
    int     stall_left;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [31:0] rol(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic qround(int a, int b, int c, int d);
        ks_words[a] += ks_words[b]; ks_words[d] = rol(ks_words[d] ^ ks_words[a], 16);
        ks_words[c] += ks_words[d]; ks_words[b] = rol(ks_words[b] ^ ks_words[c], 12);
        ks_words[a] += ks_words[b]; ks_words[d] = rol(ks_words[d] ^ ks_words[a], 8);
        ks_words[c] += ks_words[d]; ks_words[b] = rol(ks_words[b] ^ ks_words[c], 7);
    endtask

    // next 64-byte keystream block, then advance counter with carry into nonce word zero
    task automatic make_keystream_block();
        logic [31:0] init_w[16];
        init_w[0] = chacha_pkg::SIGMA0;
        init_w[1] = chacha_pkg::SIGMA1;
        init_w[2] = chacha_pkg::SIGMA2;
        init_w[3] = chacha_pkg::SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init_w[4 + 2*i] = key_reg[i][31:0];
            init_w[5 + 2*i] = key_reg[i][63:32];
        end
        init_w[12] = blk_ctr;
        init_w[13] = nonce_w0;
        init_w[14] = nonce_lo_reg[63:32];
        init_w[15] = nonce_hi_reg;
        for (int i = 0; i < 16; i++) ks_words[i] = init_w[i];
        for (int r = 0; r < 10; r++)
        begin
            qround(0, 4, 8, 12); qround(1, 5, 9, 13);
            qround(2, 6, 10, 14); qround(3, 7, 11, 15);
            qround(0, 5, 10, 15); qround(1, 6, 11, 12);
            qround(2, 7, 8, 13); qround(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) ks_words[i] += init_w[i];
        blk_ctr++;
        if (blk_ctr == 32'd0)
            nonce_w0++;
        blocks_made++;
    endtask

    task automatic restart_stream();
        blk_ctr  = ctr_init_reg;
        nonce_w0 = nonce_lo_reg[31:0];
        ks_pos   = 64;
    endtask

    function automatic logic [7:0] random_byte();
        return 8'($urandom);
    endfunction

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycles, board.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // output side: random stall bursts on tready, check on handshake
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            board.check_result(m_axis_tdata, m_axis_tlast);
            rx_total++;
        end
        if (!rst_n || quiet_phase)
        begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 1)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left == 1)
        begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // register write, then restart prediction for a used index
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            chacha_pkg::CFG_KEY0:     key_reg[0]   = val;
            chacha_pkg::CFG_KEY1:     key_reg[1]   = val;
            chacha_pkg::CFG_KEY2:     key_reg[2]   = val;
            chacha_pkg::CFG_KEY3:     key_reg[3]   = val;
            chacha_pkg::CFG_NONCE_LO: nonce_lo_reg = val;
            chacha_pkg::CFG_NONCE_HI: nonce_hi_reg = val[31:0];
            chacha_pkg::CFG_COUNTER:  ctr_init_reg = val[31:0];
            default: ;
        endcase
        if (idx <= chacha_pkg::CFG_COUNTER)
            restart_stream();
    endtask

    // send one byte, predict its result at acceptance; valid stays up until the next call
    task automatic send_byte(logic [7:0] d, logic l);
        logic [7:0] ks;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do @(posedge clk); while (!s_axis_tready);
        if (ks_pos >= 64)
        begin
            make_keystream_block();
            ks_pos = 0;
        end
        ks = 8'(ks_words[ks_pos >> 2] >> (8 * (ks_pos & 3)));
        ks_pos++;
        board.note_input(d ^ ks, l);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_run(int n);
        for (int i = 0; i < n; i++)
            send_byte(random_byte(), $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        board         = new();
        cycles        = 0;
        rx_total      = 0;
        blocks_made   = 0;
        stall_left    = 0;
        quiet_phase   = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        nonce_lo_reg = '0;
        nonce_hi_reg = '0;
        ctr_init_reg = '0;
        for (int i = 0; i < 16; i++) ks_words[i] = '0;
        restart_stream();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all-zero key, extremes of data and last, across a block boundary
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        send_run(66);
        drain();

        // all-ones registers, counter about to wrap into nonce word zero
        write_reg(chacha_pkg::CFG_KEY0, '1);
        write_reg(chacha_pkg::CFG_KEY1, '1);
        write_reg(chacha_pkg::CFG_KEY2, '1);
        write_reg(chacha_pkg::CFG_KEY3, '1);
        write_reg(chacha_pkg::CFG_NONCE_LO, '1);
        write_reg(chacha_pkg::CFG_NONCE_HI, 64'hffff_ffff);
        write_reg(chacha_pkg::CFG_COUNTER, 64'hffff_ffff);
        send_byte(8'hff, 1'b1);
        send_run(70);
        drain();

        // unused index: no effect on the stream
        write_reg(CFG_UNUSED, '1);
        send_run(10);
        drain();

        // random phases with fresh configuration
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int r = 0; r <= chacha_pkg::CFG_COUNTER; r++)
                if ($urandom_range(0, 2) != 0)
                    write_reg(IDX_W'(r), {$urandom, $urandom});
            if (ph == 3)
                write_reg(chacha_pkg::CFG_COUNTER, 64'hffff_fffe);
            write_reg(chacha_pkg::CFG_NONCE_HI, {$urandom, $urandom});
            if (ph == 7)
                quiet_phase = 1'b1;
            send_run(N_RANDOM / 8);
            drain();
        end

        repeat (BLOCK_WAIT) @(posedge clk);
        $display("covered %0d output words over %0d keystream blocks", rx_total, blocks_made);
        $display("config restarts, counter wrap and random stalls on both sides included");
        if (board.errors == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/chacha_pkg.sv
rtl/chacha_ram.sv
rtl/chacha_qr.sv
rtl/chacha20_stream_xor_core.sv
dv/chacha20_stream_xor_core_test.sv
